### hw/rtl/bounded_deque_unit_defines.svh
// Assertion macros used by the deque top level.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef BOUNDED_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque.
// No dependencies.
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN,
    CMD_APPEND,
    CMD_SHIFT_OUT,
    CMD_DROP_BACK,
    CMD_MARK,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic              tag;
    logic [DATA_W-1:0] data;
  } cell_link_t;

endpackage

### hw/rtl/bdq_cell.sv
// One storage cell of the deque chain: entry, occupancy and dump tag.
// Depends on bdq_pkg.
module bdq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  bdq_pkg::cell_link_t left,
  input  bdq_pkg::cell_link_t right,
  input  bdq_pkg::cell_link_t head,
  output bdq_pkg::cell_link_t self
);

  logic                       valid_r, valid_nxt;
  logic                       tag_r, tag_nxt;
  logic [bdq_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                       is_back;

  assign is_back = valid_r && !right.valid;

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    data_nxt  = data_r;
    case (ctrl.cmd)
      bdq_pkg::CMD_SHIFT_IN: begin
        valid_nxt = left.valid;
        tag_nxt   = left.tag;
        data_nxt  = left.data;
      end
      bdq_pkg::CMD_APPEND: begin
        // take the new entry in the first free cell
        if (!valid_r && left.valid) begin
          valid_nxt = 1'b1;
          data_nxt  = ctrl.data;
        end
      end
      bdq_pkg::CMD_SHIFT_OUT: begin
        valid_nxt = right.valid;
        tag_nxt   = right.tag;
        data_nxt  = right.data;
      end
      bdq_pkg::CMD_DROP_BACK: begin
        if (is_back) begin
          valid_nxt = 1'b0;
        end
      end
      bdq_pkg::CMD_MARK: begin
        tag_nxt = is_back;
      end
      bdq_pkg::CMD_ROTATE: begin
        // advance toward the front; the back cell takes the old front
        if (valid_r) begin
          tag_nxt  = right.valid ? right.tag : head.tag;
          data_nxt = right.valid ? right.data : head.data;
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    data_r <= data_nxt;
  end

  assign self = '{valid: valid_r, tag: tag_r, data: data_r};

endmodule

### hw/rtl/bounded_deque_unit.sv
// Top level of the bounded deque: control, result register and the cell chain.
// Depends on bdq_pkg, bdq_cell and bounded_deque_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one request carries in_operation and
//   in_data. Codes: push front, push back, pop front, pop back, dump. Codes
//   above dump are taken and dropped without a result.
//   Result channel (out_valid / out_stall): status, value and last. Every
//   push or pop yields one result; a dump yields one result per entry from
//   front to back with out_last on the back entry, or one empty result.
// Latency and throughput:
//   The result of a push or pop appears in the cycle after the request is
//   taken, and pushes and pops can be taken one per cycle while the
//   receiver does not stall. A dump first tags the back entry, then rotates
//   the chain one cell per cycle while the receiver does not stall, giving
//   one result per entry; no request is taken until the last one is loaded.
// Reset: rst_n (synchronous, active low) empties the deque and the result
//   register. Entry contents are not cleared and no sweep is needed.
// Stall: a waiting result sits in the output register; a new request is
//   taken in the same cycle as that result leaves, and a dump pauses while
//   the receiver stalls.
`include "bounded_deque_unit_defines.svh"

module bounded_deque_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bdq_pkg::STATUS_W-1:0]      out_status,
  output logic signed [bdq_pkg::DATA_W-1:0] out_value,
  output logic                              out_last
);

  bdq_pkg::state_t     state_r, state_nxt;
  bdq_pkg::cell_ctrl_t ctrl;
  bdq_pkg::cell_link_t links [DEPTH];
  bdq_pkg::cell_link_t push_link;
  bdq_pkg::cell_link_t end_link;
  bdq_pkg::op_t        op;

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] tags;
  logic             empty, full;
  logic             can_load, in_acc;
  logic [bdq_pkg::DATA_W-1:0] back_data;

  logic                         out_valid_r, out_valid_nxt;
  logic [bdq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bdq_pkg::DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         produce;

  assign op        = bdq_pkg::op_t'(in_operation);
  assign empty     = !occ[0];
  assign full      = occ[DEPTH-1];
  assign can_load  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != bdq_pkg::S_IDLE) || !can_load;
  assign in_acc    = in_valid && !in_stall;

  // cell 0 sees the new entry on its left; the last cell sees an empty slot
  assign push_link = '{valid: 1'b1, tag: 1'b0, data: $unsigned(in_data)};
  assign end_link  = '{valid: 1'b0, tag: 1'b0, data: '0};

  // ---------------------------------------------------------------- chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_pkg::cell_link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = push_link;
    end else begin : g_inner
      assign left_l = links[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign right_l = end_link;
    end else begin : g_mid
      assign right_l = links[i+1];
    end
    bdq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .left  (left_l),
      .right (right_l),
      .head  (links[0]),
      .self  (links[i])
    );
    assign occ[i]  = links[i].valid;
    assign tags[i] = links[i].tag;
  end

  // pick the back entry: the occupied cell whose right neighbor is free
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (occ[i] && ((i == DEPTH-1) || !occ[(i + 1) % DEPTH])) begin
        back_data = back_data | links[i].data;
      end
    end
  end

  // ------------------------------------------------------ next state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        if (in_acc && (op == bdq_pkg::OP_DUMP) && !empty) begin
          state_nxt = bdq_pkg::S_DUMP;
        end
      end
      bdq_pkg::S_DUMP: begin
        // the tagged back entry reaches the head last
        if (can_load && links[0].tag) begin
          state_nxt = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------- output logic
  always_comb begin
    ctrl           = '{cmd: bdq_pkg::CMD_HOLD, data: $unsigned(in_data)};
    produce        = 1'b0;
    out_status_nxt = bdq_pkg::ST_OK;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
              produce = 1'b1;
              if (full) begin
                out_status_nxt = bdq_pkg::ST_FULL;
              end else if (op == bdq_pkg::OP_PUSH_FRONT) begin
                ctrl.cmd = bdq_pkg::CMD_SHIFT_IN;
              end else begin
                ctrl.cmd = bdq_pkg::CMD_APPEND;
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              produce = 1'b1;
              if (empty) begin
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                ctrl.cmd      = bdq_pkg::CMD_SHIFT_OUT;
                out_value_nxt = links[0].data;
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              produce = 1'b1;
              if (empty) begin
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                ctrl.cmd      = bdq_pkg::CMD_DROP_BACK;
                out_value_nxt = back_data;
              end
            end
            bdq_pkg::OP_DUMP: begin
              // empty dump answers at once; otherwise tag the back entry
              if (empty) begin
                produce        = 1'b1;
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                ctrl.cmd = bdq_pkg::CMD_MARK;
              end
            end
            default: begin
              produce = 1'b0;
            end
          endcase
        end
      end
      bdq_pkg::S_DUMP: begin
        // emit the head and rotate it to the back
        if (can_load) begin
          ctrl.cmd      = bdq_pkg::CMD_ROTATE;
          produce       = 1'b1;
          out_value_nxt = links[0].data;
          out_last_nxt  = links[0].tag;
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // -------------------------------------------------------- result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_load) begin
      out_valid_nxt = produce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && can_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = $signed(out_value_r);
  assign out_last   = out_last_r;

  // ------------------------------------------------------------ assertions
  logic thermo_ok;
  assign thermo_ok = ((occ[DEPTH-1:1] & ~occ[DEPTH-2:0]) == '0);

  `BDQ_ASSERT_NOW(a_occ_thermo, 1'b1, thermo_ok, "occupancy has a hole")
  `BDQ_ASSERT_NOW(a_dump_nonempty, state_r == bdq_pkg::S_DUMP, occ[0], "dump with empty deque")
  `BDQ_ASSERT_NOW(a_dump_one_tag, state_r == bdq_pkg::S_DUMP, $onehot(tags & occ), "dump tag lost")
  `BDQ_ASSERT_NEXT(a_dump_keeps_occ, state_r == bdq_pkg::S_DUMP, $stable(occ), "dump changed occupancy")
  `BDQ_ASSERT_NEXT(a_full_reject, in_acc && full && (op == bdq_pkg::OP_PUSH_BACK), out_valid_r && (out_status_r == bdq_pkg::ST_FULL) && $stable(occ), "full push not rejected")

endmodule

### dv/tb_bounded_deque_unit.sv
// Self-checking bench for bounded_deque_unit: directed corner requests, then random
// fill, drain and mixed sequences with stalls on both channels.
// Depends on bdq_pkg and the bounded_deque_unit RTL.
module tb_bounded_deque_unit;
  import bdq_pkg::*;

  localparam int DEPTH           = DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 350;
  // Once fewer requests than this are pending, both sides start no new idle bursts.
  localparam int TAIL_REQUESTS   = 40;
  // Cycles to watch for stray results after the last expected one.
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int MAX_BURST       = 16;

  // Codes above dump are taken by the block and dropped without a result.
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] data;
  } deque_request_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } deque_result_t;

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = '0;
  logic signed [DATA_W-1:0] in_data      = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  bounded_deque_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_value   (out_value),
    .out_last    (out_last)
  );

  // Requests waiting to be driven, filled up front by the stimulus block.
  deque_request_t           pending_requests[$];
  // Contents of the deque as the block should hold them, front first.
  logic signed [DATA_W-1:0] deque_contents[$];
  // Results the block still owes, oldest first.
  deque_result_t            owed_results[$];

  // Occupancy as seen while planning stimulus, used to shape fill and drain runs.
  int plan_level      = 0;
  int planned_counted = 0;

  int mismatches      = 0;
  int results_checked = 0;
  int push_count      = 0;
  int pop_count       = 0;
  int dump_count      = 0;
  int longest_dump    = 0;
  int full_rejects    = 0;
  int empty_reports   = 0;
  int dropped_codes   = 0;

  deque_request_t next_request;
  deque_result_t  oldest_result;

  // Idle shaping: a burst counter per side, plus a slowly changing switch
  // so that long stretches run with no idling at all.
  int in_gap       = 0;
  int in_weather   = 0;
  bit in_idle_on   = 1'b0;
  int out_gap      = 0;
  int out_weather  = 0;
  bit out_idle_on  = 1'b0;

  function automatic bit tail_reached();
    return pending_requests.size() < TAIL_REQUESTS;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------------

  task automatic owe_result(input status_t status, input logic signed [DATA_W-1:0] value,
                            input logic last);
    deque_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    owed_results.push_back(r);
  endtask

  // Apply one accepted request to the deque contents and queue what it must produce.
  task automatic apply_request(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] data);
    logic signed [DATA_W-1:0] taken;
    int n;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        push_count++;
        if (deque_contents.size() >= DEPTH) begin
          // Reject a push into a full deque; contents stay as they are.
          full_rejects++;
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            deque_contents.push_front(data);
          end else begin
            deque_contents.push_back(data);
          end
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        pop_count++;
        if (deque_contents.size() == 0) begin
          empty_reports++;
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (op == OP_POP_FRONT) begin
            taken = deque_contents.pop_front();
          end else begin
            taken = deque_contents.pop_back();
          end
          owe_result(ST_OK, taken, 1'b1);
        end
      end
      OP_DUMP: begin
        dump_count++;
        n = deque_contents.size();
        if (n == 0) begin
          empty_reports++;
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          // Emit every entry front to back; only the back entry carries last.
          if (n > longest_dump) longest_dump = n;
          for (int i = 0; i < n; i++) begin
            owe_result(ST_OK, deque_contents[i], (i == n - 1));
          end
        end
      end
      default: begin
        dropped_codes++;
      end
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] check failed: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  // Queue one request and track the occupancy it leads to.
  task automatic plan_request(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] data);
    deque_request_t r;
    r.op   = op;
    r.data = data;
    pending_requests.push_back(r);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (plan_level < DEPTH) plan_level++;
      OP_POP_FRONT, OP_POP_BACK:   if (plan_level > 0) plan_level--;
      default: ;
    endcase
    if (op <= OP_DUMP) planned_counted++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_push();
    return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic logic [OP_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  function automatic logic [OP_W-1:0] pick_mixed();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)  return pick_push();
    if (r < 16) return pick_pop();
    if (r < 19) return OP_DUMP;
    return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  task automatic plan_directed();
    // Empty deque: every read-type request reports empty.
    plan_request(OP_DUMP, '0);
    plan_request(OP_POP_FRONT, '1);
    plan_request(OP_POP_BACK, '0);
    // Extreme values on both ends; push front shifts the whole chain toward the back.
    plan_request(OP_PUSH_BACK, 32'sh7fff_ffff);
    plan_request(OP_PUSH_FRONT, 32'sh8000_0000);
    plan_request(OP_PUSH_BACK, '0);
    plan_request(OP_PUSH_FRONT, '1);
    plan_request(OP_DUMP, 32'sh5555_5555);
    plan_request(OP_POP_FRONT, 32'shaaaa_aaaa);
    plan_request(OP_POP_BACK, '0);
    // Unused codes must leave the deque alone and produce nothing.
    plan_request(OP_UNUSED_FIRST, '1);
    plan_request(3'd6, 32'sh1234_5678);
    plan_request(OP_UNUSED_LAST, '0);
    plan_request(OP_DUMP, '0);
    plan_request(OP_POP_BACK, '0);
    plan_request(OP_POP_FRONT, '0);
    // Drained again: pop and dump on empty.
    plan_request(OP_POP_FRONT, '0);
    plan_request(OP_POP_BACK, '1);
    plan_request(OP_DUMP, '1);
  endtask

  task automatic plan_random();
    int phase;
    int n;
    planned_counted = 0;
    while (planned_counted < RANDOM_REQUESTS) begin
      phase = $urandom_range(0, 9);
      if (phase < 3) begin
        // Fill to the brim and push past it, then often dump a full deque.
        n = DEPTH - plan_level + $urandom_range(1, 3);
        repeat (n) plan_request(pick_push(), pick_data());
        if ($urandom_range(0, 1)) plan_request(OP_DUMP, pick_data());
      end else if (phase < 6) begin
        // Drain to empty and pop past it.
        n = plan_level + $urandom_range(1, 2);
        if ($urandom_range(0, 2) == 0) plan_request(OP_DUMP, pick_data());
        repeat (n) plan_request(pick_pop(), pick_data());
        if ($urandom_range(0, 1)) plan_request(OP_DUMP, pick_data());
      end else if (phase < 9) begin
        repeat ($urandom_range(8, 20)) plan_request(pick_mixed(), pick_data());
      end else begin
        // Noise: any code, any data.
        repeat ($urandom_range(3, 6)) plan_request(OP_W'($urandom_range(0, 7)), pick_data());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and run control
  // ---------------------------------------------------------------------------

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    plan_directed();
    plan_random();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Hold until every request has gone in and every owed result has come out.
    while (pending_requests.size() != 0 || in_valid || owed_results.size() != 0) begin
      @(negedge clk);
    end
    // Watch a while longer for results nobody asked for.
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d pushes (%0d rejected as full), %0d pops and %0d dumps (up to %0d entries);",
             push_count, full_rejects, pop_count, dump_count, longest_dump);
    $display("%0d results checked, %0d empty reports, %0d unused codes dropped.",
             results_checked, empty_reports, dropped_codes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d failed checks", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #5_000_000;
    $display("Timed out with %0d requests pending and %0d results owed",
             pending_requests.size(), owed_results.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_weather == 0) begin
        in_weather = $urandom_range(20, 120);
        in_idle_on = ($urandom_range(0, 2) != 0);
      end else begin
        in_weather--;
      end
      // Record a request the block takes at this edge.
      if (in_valid && !in_stall) begin
        apply_request(in_operation, in_data);
      end
      // Hold a stalled request; otherwise pick what to present next.
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0 && !tail_reached() && in_idle_on &&
                     $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, MAX_BURST) - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_request = pending_requests.pop_front();
          in_valid     <= 1'b1;
          in_operation <= next_request.op;
          in_data      <= next_request.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (out_weather == 0) begin
      out_weather = $urandom_range(20, 120);
      out_idle_on = ($urandom_range(0, 2) != 0);
    end else begin
      out_weather--;
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!tail_reached() && out_idle_on && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(1, MAX_BURST) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each delivered result with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (owed_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d value %0d last %0b",
                                out_status, out_value, out_last));
      end else begin
        oldest_result = owed_results.pop_front();
        if (out_status !== oldest_result.status) begin
          note_mismatch($sformatf("status expected %0d got %0d",
                                  oldest_result.status, out_status));
        end
        if (out_value !== oldest_result.value) begin
          note_mismatch($sformatf("value expected %0d (0x%08h) got %0d (0x%08h)",
                                  oldest_result.value, oldest_result.value,
                                  out_value, out_value));
        end
        if (out_last !== oldest_result.last) begin
          note_mismatch($sformatf("last expected %0b got %0b",
                                  oldest_result.last, out_last));
        end
      end
    end
  end

endmodule
